/* rtl/assert_macros.svh */
// assertion macros used by the heap engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define AST_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked out of reset
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/tkhf_pkg.sv */
// types, constants and compare functions of the top-k heap filter
package tkhf_pkg;

    localparam int MAX_K = 64;
    localparam int AW    = $clog2(MAX_K);
    localparam int KW    = AW + 1;

    localparam logic [31:0] FILL_LARGEST = 32'h7f7f_ffff;
    localparam logic [31:0] FILL_SMALL   = 32'h38d1_b717;
    localparam logic [63:0] LABEL_EMPTY  = 64'hffff_ffff_ffff_ffff;

    // configuration register indexes
    localparam logic [1:0] REG_KEEP  = 2'd0;
    localparam logic [1:0] REG_HEAP  = 2'd1;
    localparam logic [1:0] REG_BURST = 2'd2;

    typedef enum logic [1:0] {
        ACT_HDR  = 2'd0,
        ACT_CAND = 2'd1,
        ACT_FIN  = 2'd2,
        ACT_NONE = 2'd3
    } t_act;

    // which of parent, left child, right child is worst
    typedef enum logic [1:0] {
        SEL_X = 2'd0,
        SEL_L = 2'd1,
        SEL_R = 2'd2
    } t_sel;

    typedef struct packed {
        logic        load;
        logic        last;
        logic [31:0] distance;
        logic [63:0] label;
    } t_res;

    function automatic logic [31:0] order_key(input logic [31:0] b);
        return b[31] ? ~b : (b | 32'h8000_0000);
    endfunction

    // a strictly worse than b for the mode
    function automatic logic worse(input logic [31:0] a, input logic [31:0] b,
                                   input logic keep);
        logic [31:0] ka;
        logic [31:0] kb;
        ka = order_key(a);
        kb = order_key(b);
        return keep ? (ka > kb) : (ka < kb);
    endfunction

    function automatic logic [31:0] fill_dist(input logic keep);
        return keep ? FILL_LARGEST : FILL_SMALL;
    endfunction

endpackage

/* rtl/tkhf_pick.sv */
// shared compare unit: picks the worst of a parent and its two children
module tkhf_pick (
    input  logic               i_keep,
    input  logic [31:0]        i_x,
    input  logic [31:0]        i_l,
    input  logic [31:0]        i_r,
    input  logic               i_l_en,
    input  logic               i_r_en,
    output tkhf_pkg::t_sel     o_sel
);

    logic        w_lw;
    logic        w_rw;
    logic [31:0] w_mid;

    assign w_lw  = i_l_en && tkhf_pkg::worse(i_l, i_x, i_keep);
    assign w_mid = w_lw ? i_l : i_x;
    // right child only wins if strictly worse than the current pick
    assign w_rw  = i_r_en && tkhf_pkg::worse(i_r, w_mid, i_keep);

    always_comb begin
        if (w_rw) begin
            o_sel = tkhf_pkg::SEL_R;
        end else if (w_lw) begin
            o_sel = tkhf_pkg::SEL_L;
        end else begin
            o_sel = tkhf_pkg::SEL_X;
        end
    end

endmodule

/* rtl/tkhf_engine.sv */
// heap store, sift-down sequencer, heap sort and result read-out
`include "assert_macros.svh"

module tkhf_engine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_keep,
    input  logic [tkhf_pkg::KW-1:0]   i_k,
    input  logic [15:0]               i_burst,
    input  logic                      i_clear,
    input  logic                      i_start,
    input  logic [1:0]                i_action,
    input  logic [31:0]               i_dist,
    input  logic [63:0]               i_label,
    input  logic                      i_out_free,
    output logic                      o_idle,
    output tkhf_pkg::t_res            o_res
);

    localparam int AW = tkhf_pkg::AW;
    localparam int KW = tkhf_pkg::KW;
    localparam int EW = 96;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_CHK  = 9'b000000010,
        S_FIN  = 9'b000000100,
        S_SWRD = 9'b000001000,
        S_SWWR = 9'b000010000,
        S_RD   = 9'b000100000,
        S_SIFT = 9'b001000000,
        S_ERD  = 9'b010000000,
        S_ELD  = 9'b100000000
    } t_state;

    t_state               r_state, n_state;
    tkhf_pkg::t_act       r_act, n_act;
    logic [31:0]          r_in_dist, n_in_dist;
    logic [63:0]          r_in_lab, n_in_lab;
    logic [15:0]          r_skip, n_skip;
    logic [31:0]          r_x_dist, n_x_dist;
    logic [63:0]          r_x_lab, n_x_lab;
    logic [AW-1:0]        r_pos, n_pos;
    logic [KW-1:0]        r_len, n_len;
    logic                 r_sort, n_sort;
    logic [AW-1:0]        r_i, n_i;
    logic [AW-1:0]        r_e, n_e;

    logic [EW-1:0]        mem [tkhf_pkg::MAX_K];
    logic [EW-1:0]        r_rda, r_rdb;
    logic                 r_rda_vld, r_rdb_vld;
    logic [tkhf_pkg::MAX_K-1:0] r_vld;
    logic [31:0]          r_top;
    logic                 r_top_vld;

    logic [AW-1:0]        w_raddr_a, w_raddr_b;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [EW-1:0]        w_wdata;
    logic                 w_clr;
    logic                 w_load;
    logic                 w_last;

    logic [31:0]          w_fill;
    logic [31:0]          w_a_dist, w_b_dist, w_top_dist;
    logic [63:0]          w_a_lab, w_b_lab;
    logic [KW-1:0]        w_pl;
    logic [KW:0]          w_pr;
    logic                 w_l_en, w_r_en;
    logic [AW-1:0]        w_m;
    logic [KW-1:0]        w_ml;
    logic [KW:0]          w_mr;

    logic [31:0]          w_px, w_pl_d, w_pr_d;
    logic                 w_pl_en, w_pr_en;
    tkhf_pkg::t_sel       w_sel;
    logic                 w_beats;
    tkhf_pkg::t_act       w_act;

    // entries never written since the last refill read as the empty fill
    assign w_fill     = tkhf_pkg::fill_dist(i_keep);
    assign w_a_dist   = r_rda_vld ? r_rda[31:0]  : w_fill;
    assign w_a_lab    = r_rda_vld ? r_rda[95:32] : tkhf_pkg::LABEL_EMPTY;
    assign w_b_dist   = r_rdb_vld ? r_rdb[31:0]  : w_fill;
    assign w_b_lab    = r_rdb_vld ? r_rdb[95:32] : tkhf_pkg::LABEL_EMPTY;
    assign w_top_dist = r_top_vld ? r_top : w_fill;

    // children of the current position
    assign w_pl   = {r_pos, 1'b1};
    assign w_pr   = {1'b0, r_pos, 1'b1} + (KW+1)'(1);
    assign w_l_en = w_pl < r_len;
    assign w_r_en = w_pr < {1'b0, r_len};

    // shared compare: top against incoming item, or parent against children
    always_comb begin
        if (r_state == S_CHK) begin
            w_px    = r_in_dist;
            w_pl_d  = w_top_dist;
            w_pr_d  = w_top_dist;
            w_pl_en = 1'b1;
            w_pr_en = 1'b0;
        end else begin
            w_px    = r_x_dist;
            w_pl_d  = w_a_dist;
            w_pr_d  = w_b_dist;
            w_pl_en = w_l_en;
            w_pr_en = w_r_en;
        end
    end

    tkhf_pick u_pick (
        .i_keep (i_keep),
        .i_x    (w_px),
        .i_l    (w_pl_d),
        .i_r    (w_pr_d),
        .i_l_en (w_pl_en),
        .i_r_en (w_pr_en),
        .o_sel  (w_sel)
    );

    assign w_beats = (w_sel == tkhf_pkg::SEL_L);
    assign w_m     = (w_sel == tkhf_pkg::SEL_R) ? w_pr[AW-1:0] : w_pl[AW-1:0];
    assign w_ml    = {w_m, 1'b1};
    assign w_mr    = {1'b0, w_m, 1'b1} + (KW+1)'(1);
    assign w_last  = ({1'b0, r_e} == (i_k - KW'(1)));
    assign w_act   = tkhf_pkg::t_act'(i_action);

    // read addresses
    always_comb begin
        w_raddr_a = '0;
        w_raddr_b = '0;
        unique case (r_state)
            S_SWRD: begin
                w_raddr_a = '0;
                w_raddr_b = r_i;
            end
            S_RD: begin
                w_raddr_a = w_pl[AW-1:0];
                w_raddr_b = w_pr[AW-1:0];
            end
            S_SIFT: begin
                w_raddr_a = w_ml[AW-1:0];
                w_raddr_b = w_mr[AW-1:0];
            end
            S_ERD, S_ELD: begin
                w_raddr_a = r_e;
                w_raddr_b = r_e;
            end
            default: begin
                w_raddr_a = '0;
                w_raddr_b = '0;
            end
        endcase
    end

    // write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = {r_x_lab, r_x_dist};
        if (r_state == S_SWWR) begin
            w_we    = 1'b1;
            w_waddr = r_i;
            w_wdata = {w_a_lab, w_a_dist};
        end else if (r_state == S_SIFT) begin
            w_we    = 1'b1;
            w_waddr = r_pos;
            case (w_sel)
                tkhf_pkg::SEL_L: w_wdata = {w_a_lab, w_a_dist};
                tkhf_pkg::SEL_R: w_wdata = {w_b_lab, w_b_dist};
                default:         w_wdata = {r_x_lab, r_x_dist};
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_in_dist = r_in_dist;
        n_in_lab  = r_in_lab;
        n_skip    = r_skip;
        n_x_dist  = r_x_dist;
        n_x_lab   = r_x_lab;
        n_pos     = r_pos;
        n_len     = r_len;
        n_sort    = r_sort;
        n_i       = r_i;
        n_e       = r_e;
        w_load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_act     = w_act;
                    n_in_dist = i_dist;
                    n_in_lab  = i_label;
                    case (w_act) inside
                        tkhf_pkg::ACT_HDR, tkhf_pkg::ACT_CAND: n_state = S_CHK;
                        tkhf_pkg::ACT_FIN:                      n_state = S_FIN;
                        default:                                n_state = S_IDLE;
                    endcase
                end
            end
            S_CHK: begin
                n_state = S_IDLE;
                if (r_act == tkhf_pkg::ACT_HDR) begin
                    n_skip = w_beats ? 16'd0 : i_burst;
                end else if (r_skip != 16'd0) begin
                    n_skip = r_skip - 16'd1;
                end else if (w_beats) begin
                    n_x_dist = r_in_dist;
                    n_x_lab  = r_in_lab;
                    n_pos    = '0;
                    n_len    = i_k;
                    n_sort   = 1'b0;
                    n_state  = S_RD;
                end
            end
            S_FIN: begin
                n_sort = 1'b1;
                n_e    = '0;
                if (i_k == KW'(1)) begin
                    n_state = S_ERD;
                end else begin
                    n_i     = AW'(i_k - KW'(1));
                    n_state = S_SWRD;
                end
            end
            S_SWRD: begin
                n_state = S_SWWR;
            end
            S_SWWR: begin
                // old top goes to slot i, slot i's entry sifts down from the top
                n_x_dist = w_b_dist;
                n_x_lab  = w_b_lab;
                n_pos    = '0;
                n_len    = {1'b0, r_i};
                n_state  = S_RD;
            end
            S_RD: begin
                n_state = S_SIFT;
            end
            S_SIFT: begin
                if (w_sel == tkhf_pkg::SEL_X) begin
                    if (!r_sort) begin
                        n_state = S_IDLE;
                    end else if (r_i == AW'(1)) begin
                        n_state = S_ERD;
                    end else begin
                        n_i     = r_i - AW'(1);
                        n_state = S_SWRD;
                    end
                end else begin
                    n_pos = w_m;
                end
            end
            S_ERD: begin
                n_state = S_ELD;
            end
            S_ELD: begin
                if (i_out_free) begin
                    w_load = 1'b1;
                    if (w_last) begin
                        n_skip  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_e     = r_e + AW'(1);
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_clear) begin
            n_skip = '0;
        end
    end

    assign w_clr = i_clear || (w_load && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_skip  <= '0;
            r_sort  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_skip  <= n_skip;
            r_sort  <= n_sort;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_in_dist <= n_in_dist;
        r_in_lab  <= n_in_lab;
        r_x_dist  <= n_x_dist;
        r_x_lab   <= n_x_lab;
        r_pos     <= n_pos;
        r_len     <= n_len;
        r_i       <= n_i;
        r_e       <= n_e;
    end

    // heap store, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rda <= mem[w_raddr_a];
        r_rdb <= mem[w_raddr_b];
    end

    // copy of the top entry's distance for header and candidate checks
    always_ff @(posedge i_clk) begin
        if (w_we && (w_waddr == '0)) begin
            r_top <= w_wdata[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_top_vld <= 1'b0;
            r_rda_vld <= 1'b0;
            r_rdb_vld <= 1'b0;
        end else begin
            r_rda_vld <= r_vld[w_raddr_a];
            r_rdb_vld <= r_vld[w_raddr_b];
            if (w_clr) begin
                r_vld     <= '0;
                r_top_vld <= 1'b0;
            end else if (w_we) begin
                r_vld[w_waddr] <= 1'b1;
                if (w_waddr == '0) begin
                    r_top_vld <= 1'b1;
                end
            end
        end
    end

    assign o_idle         = (r_state == S_IDLE);
    assign o_res.load     = w_load;
    assign o_res.last     = w_last;
    assign o_res.distance = w_a_dist;
    assign o_res.label    = w_a_lab;

    `AST_IMPLY(a_sift_in_heap, i_clk, i_rst_n, r_state == S_SIFT, KW'(r_pos) < r_len)
    `AST_NEXT(a_skip_count, i_clk, i_rst_n, (r_state == S_CHK) && (r_act == tkhf_pkg::ACT_CAND) && (r_skip != 16'd0) && !i_clear, r_skip == ($past(r_skip) - 16'd1))
    `AST_NEXT(a_refill_at_end, i_clk, i_rst_n, w_load && w_last && !i_start, (r_state == S_IDLE) && !r_top_vld)

endmodule

/* rtl/topk_heap_burst_filter.sv */
// top level of the top-k heap filter: register port, handshakes, result register
//
//  channel   direction  handshake                    payload
//  cfg       in         psel/penable/pwrite, pready  paddr, pwdata (prdata back)
//  item      in         i_in_valid / o_in_stall      i_action, i_distance_bits, i_item_label
//  result    out        o_out_valid / i_out_stall    o_result_distance, o_result_label,
//                                                    o_last_result
//
//  header, dropped or losing candidate: transfer, then top compare
//  winning candidate: transfer, top compare, child read, then one heap level per cycle of the shared compare
//  finish with k entries: (k-1) swap and sift-down sort steps, then a read and a load per result
//  reset: synchronous, valid bits clear at once, no clearing pass; item input stalls
//  while a query step is in work, and a stalled result holds the read-out until it is taken

module topk_heap_burst_filter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // item channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [31:0]        i_distance_bits,
    input  logic signed [63:0] i_item_label,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_result_distance,
    output logic signed [63:0] o_result_label,
    output logic               o_last_result
);

    localparam int KW = tkhf_pkg::KW;

    logic               r_keep;
    logic [6:0]         r_heap_size;
    logic [15:0]        r_burst;

    logic               r_out_vld;
    logic [31:0]        r_out_dist;
    logic signed [63:0] r_out_lab;
    logic               r_out_last;

    logic               w_wr;
    logic [1:0]         w_idx;
    logic               w_clear;
    logic [KW-1:0]      w_k;
    logic               w_idle;
    logic               w_start;
    logic               w_out_free;
    tkhf_pkg::t_res     w_res;

    // register writes on the access phase
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep      <= 1'b1;
            r_heap_size <= 7'd64;
            r_burst     <= 16'd64;
        end else if (w_wr) begin
            unique case (w_idx)
                tkhf_pkg::REG_KEEP:  r_keep      <= pwdata[0];
                tkhf_pkg::REG_HEAP:  r_heap_size <= pwdata[6:0];
                tkhf_pkg::REG_BURST: r_burst     <= pwdata[15:0];
                default:             r_burst     <= r_burst;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            tkhf_pkg::REG_KEEP:  prdata = {31'd0, r_keep};
            tkhf_pkg::REG_HEAP:  prdata = {25'd0, r_heap_size};
            tkhf_pkg::REG_BURST: prdata = {16'd0, r_burst};
            default:             prdata = '0;
        endcase
    end

    // changing mode or k refills the heap and drops any pending skip
    assign w_clear = w_wr && ((w_idx == tkhf_pkg::REG_KEEP) || (w_idx == tkhf_pkg::REG_HEAP));

    // effective k: zero acts as one, anything above the heap depth saturates
    always_comb begin
        if (r_heap_size == 7'd0) begin
            w_k = KW'(1);
        end else if (r_heap_size > 7'(tkhf_pkg::MAX_K)) begin
            w_k = KW'(tkhf_pkg::MAX_K);
        end else begin
            w_k = KW'(r_heap_size);
        end
    end

    // item transfer only while the sequencer is idle
    assign o_in_stall = !w_idle;
    assign w_start    = i_in_valid && w_idle;

    // result register frees up on its own transfer
    assign w_out_free = !r_out_vld || !i_out_stall;

    tkhf_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_keep     (r_keep),
        .i_k        (w_k),
        .i_burst    (r_burst),
        .i_clear    (w_clear),
        .i_start    (w_start),
        .i_action   (i_action),
        .i_dist     (i_distance_bits),
        .i_label    ($unsigned(i_item_label)),
        .i_out_free (w_out_free),
        .o_idle     (w_idle),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res.load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.load) begin
            r_out_dist <= w_res.distance;
            r_out_lab  <= $signed(w_res.label);
            r_out_last <= w_res.last;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_result_distance = r_out_dist;
    assign o_result_label    = r_out_lab;
    assign o_last_result     = r_out_last;

endmodule
